// ===== rtl/kpm_pkg.sv =====
// Shared types, constants and register codes for the keypoint match filter.
// Used by every module of the block except kpm_ram; no dependencies.
`default_nettype none

package kpm_pkg;

    localparam int POINTS  = 64;
    localparam int PT_W    = $clog2(POINTS);
    localparam int IDX_W   = 6;
    localparam int DIST_W  = 10;
    localparam int RATIO_W = 9;
    localparam int USED_W  = 7;
    localparam int OP_W    = 2;
    localparam int CNT_W   = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int PROD_W  = RATIO_W + DIST_W;

    localparam logic [IDX_W:0]  TGT_LIMIT  = (IDX_W + 1)'(POINTS);
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(POINTS);

    localparam logic [OP_W-1:0] OP_FWD = 2'd0;
    localparam logic [OP_W-1:0] OP_REV = 2'd1;
    localparam logic [OP_W-1:0] OP_FIN = 2'd2;

    localparam logic [1:0] REG_DIST_LIMIT  = 2'd0;
    localparam logic [1:0] REG_RATIO_LIMIT = 2'd1;
    localparam logic [1:0] REG_POINTS_A    = 2'd2;
    localparam logic [1:0] REG_POINTS_B    = 2'd3;

    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    localparam logic [DIST_W-1:0]  DIST_LIMIT_RST  = 10'd512;
    localparam logic [RATIO_W-1:0] RATIO_LIMIT_RST = 9'd204;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
        logic [IDX_W-1:0]  src;
    } kpm_entry_t;

    localparam int ENTRY_W = $bits(kpm_entry_t);

endpackage

`default_nettype wire

// ===== rtl/kpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/kpm_update.sv =====
// Table entry update for one loaded match: best/second tracking and count.
// Depends on kpm_pkg.
`default_nettype none

module kpm_update (
    input  wire kpm_pkg::kpm_entry_t           old_entry,
    input  wire logic                          old_valid,
    input  wire logic [kpm_pkg::DIST_W-1:0]    dist_in,
    input  wire logic [kpm_pkg::IDX_W-1:0]     src,
    input  wire logic [kpm_pkg::DIST_W-1:0]    dist_limit,
    output kpm_pkg::kpm_entry_t                new_entry,
    output logic                               keep
);
    import kpm_pkg::*;

    logic [CNT_W-1:0] cnt;

    assign keep = (dist_in <= dist_limit);
    assign cnt  = old_valid ? old_entry.cnt : CNT_NONE;

    always_comb
    begin
        new_entry = old_entry;
        if (cnt == CNT_NONE)
        begin
            new_entry.best = dist_in;
            new_entry.src  = src;
            new_entry.cnt  = CNT_ONE;
        end
        else
        begin
            // a tie leaves the earlier match in first place
            if (dist_in < old_entry.best)
            begin
                new_entry.second = old_entry.best;
                new_entry.best   = dist_in;
                new_entry.src    = src;
            end
            else if ((cnt == CNT_ONE) || (dist_in < old_entry.second))
            begin
                new_entry.second = dist_in;
            end
            new_entry.cnt = CNT_TWO;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kpm_survive.sv =====
// Shared ratio-test unit: decides whether a table entry's best match survives.
// Depends on kpm_pkg.
`default_nettype none

module kpm_survive (
    input  wire kpm_pkg::kpm_entry_t          entry,
    input  wire logic                         entry_valid,
    input  wire logic [kpm_pkg::RATIO_W-1:0]  ratio_limit,
    output logic                              survives
);
    import kpm_pkg::*;

    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] best_scaled;

    assign cnt         = entry_valid ? entry.cnt : CNT_NONE;
    assign prod        = PROD_W'(ratio_limit) * PROD_W'(entry.second);
    assign best_scaled = PROD_W'({entry.best, 8'd0});

    always_comb
    begin
        case (cnt)
            CNT_NONE: survives = 1'b0;
            CNT_ONE:  survives = 1'b1;
            default:  survives = (best_scaled < prod);
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/keypoint_match_ratio_cross_check_unit.sv =====
// Top level of the keypoint match filter: sequencer, tables, config port.
// Depends on kpm_pkg, kpm_ram, kpm_update and kpm_survive.
//
// Usage:
//   Input transfer: start high while busy is low; op, source_point,
//   target_point and distance are sampled at that edge. Forward (A to B)
//   and reverse (B to A) matches each do one table read and one
//   table write through the shared update unit. busy is high for 1 cycle.
//   A finish item walks the A points in order through one shared ratio-test
//   unit: each A point gets a reverse-entry read and test, and a forward-entry
//   test as well when its reverse survivor names a B point in use.
//   Results appear on result_valid for one cycle each with point_a, point_b,
//   match_distance, found and last; a result is held back until the next
//   survivor or the end of the walk is known, so last is exact. The final
//   result comes in the cycle in which busy drops; the receiver cannot stall.
//   If no mutual match exists a single result with found low is given.
//   After finish both tables are empty again (per-entry valid flops all cleared
//   together in the end state). Reset empties the tables and loads the register defaults.
//   Config: APB writes at byte address 4*i, only while the block is idle.
`default_nettype none

module keypoint_match_ratio_cross_check_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [kpm_pkg::OP_W-1:0]      op,
    input  wire logic [kpm_pkg::IDX_W-1:0]     source_point,
    input  wire logic [kpm_pkg::IDX_W-1:0]     target_point,
    input  wire logic [kpm_pkg::DIST_W-1:0]    distance,
    output logic                               result_valid,
    output logic      [kpm_pkg::IDX_W-1:0]     point_a,
    output logic      [kpm_pkg::IDX_W-1:0]     point_b,
    output logic      [kpm_pkg::DIST_W-1:0]    match_distance,
    output logic                               found,
    output logic                               last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kpm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [kpm_pkg::PDATA_W-1:0]   pwdata,
    output logic      [kpm_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import kpm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_RA   = 3'd2;
    localparam logic [2:0] S_CA   = 3'd3;
    localparam logic [2:0] S_CB   = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    // configuration
    logic [DIST_W-1:0]  dist_limit_reg;
    logic [RATIO_W-1:0] ratio_limit_reg;
    logic [USED_W-1:0]  points_a_reg;
    logic [USED_W-1:0]  points_b_reg;
    logic               cfg_write;
    logic [1:0]         cfg_index;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [PT_W-1:0]   a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic [POINTS-1:0] vld_fwd_reg, vld_fwd_next;
    logic [POINTS-1:0] vld_rev_reg, vld_rev_next;

    logic              pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]  pend_a_reg, pend_a_next;
    logic [IDX_W-1:0]  pend_b_reg, pend_b_next;
    logic [DIST_W-1:0] pend_d_reg, pend_d_next;

    logic              out_vld_reg, out_vld_next;
    logic [IDX_W-1:0]  out_a_reg, out_a_next;
    logic [IDX_W-1:0]  out_b_reg, out_b_next;
    logic [DIST_W-1:0] out_d_reg, out_d_next;
    logic              out_found_reg, out_found_next;
    logic              out_last_reg, out_last_next;

    // tables
    kpm_entry_t      fwd_rdata, rev_rdata;
    logic [PT_W-1:0] fwd_raddr, rev_raddr;
    logic            fwd_we, rev_we;
    logic [PT_W-1:0] wr_addr;

    // shared units
    kpm_entry_t upd_old, upd_new;
    logic       upd_old_valid, upd_keep;
    kpm_entry_t srv_entry;
    logic       srv_valid, srv_ok;

    logic              accept;
    logic              tgt_in_range;
    logic [USED_W-1:0] na, nb;
    logic [USED_W-1:0] a_inc;
    logic              a_done;
    logic [PT_W-1:0]   b_idx;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];
    assign pready    = 1'b1;

    assign na     = (points_a_reg > USED_MAX) ? USED_MAX : points_a_reg;
    assign nb     = (points_b_reg > USED_MAX) ? USED_MAX : points_b_reg;
    assign a_inc  = USED_W'(a_reg) + USED_W'(1);
    assign a_done = (a_inc >= na);
    assign b_idx  = b_reg[PT_W-1:0];

    assign tgt_in_range = ({1'b0, tgt_reg} < TGT_LIMIT);

    always_comb
    begin
        case (cfg_index)
            REG_DIST_LIMIT:  prdata = PDATA_W'(dist_limit_reg);
            REG_RATIO_LIMIT: prdata = PDATA_W'(ratio_limit_reg);
            REG_POINTS_A:    prdata = PDATA_W'(points_a_reg);
            REG_POINTS_B:    prdata = PDATA_W'(points_b_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_limit_reg  <= DIST_LIMIT_RST;
            ratio_limit_reg <= RATIO_LIMIT_RST;
            points_a_reg    <= USED_MAX;
            points_b_reg    <= USED_MAX;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DIST_LIMIT:  dist_limit_reg  <= pwdata[DIST_W-1:0];
                REG_RATIO_LIMIT: ratio_limit_reg <= pwdata[RATIO_W-1:0];
                REG_POINTS_A:    points_a_reg    <= pwdata[USED_W-1:0];
                REG_POINTS_B:    points_b_reg    <= pwdata[USED_W-1:0];
                default:         ;
            endcase
        end
    end

    // table read ports: load reads the target straight off the input,
    // the walk reads A first and then the B that the reverse entry names
    always_comb
    begin
        rev_raddr = a_reg;
        fwd_raddr = b_idx;
        case (state_reg)
            S_IDLE:
            begin
                rev_raddr = target_point[PT_W-1:0];
                fwd_raddr = target_point[PT_W-1:0];
            end
            S_CA:    fwd_raddr = rev_rdata.src[PT_W-1:0];
            default: ;
        endcase
    end

    assign wr_addr = tgt_reg[PT_W-1:0];
    assign fwd_we  = (state_reg == S_UPD) && (op_reg == OP_FWD) && upd_keep && tgt_in_range;
    assign rev_we  = (state_reg == S_UPD) && (op_reg == OP_REV) && upd_keep && tgt_in_range;

    kpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POINTS)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (fwd_we),
        .waddr (wr_addr),
        .wdata (upd_new),
        .raddr (fwd_raddr),
        .rdata (fwd_rdata)
    );

    kpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POINTS)
    ) u_rev_ram (
        .clk   (clk),
        .we    (rev_we),
        .waddr (wr_addr),
        .wdata (upd_new),
        .raddr (rev_raddr),
        .rdata (rev_rdata)
    );

    assign upd_old       = (op_reg == OP_FWD) ? fwd_rdata : rev_rdata;
    assign upd_old_valid = (op_reg == OP_FWD) ? vld_fwd_reg[wr_addr] : vld_rev_reg[wr_addr];

    kpm_update u_update (
        .old_entry  (upd_old),
        .old_valid  (upd_old_valid),
        .dist_in    (dist_reg),
        .src        (src_reg),
        .dist_limit (dist_limit_reg),
        .new_entry  (upd_new),
        .keep       (upd_keep)
    );

    assign srv_entry = (state_reg == S_CB) ? fwd_rdata : rev_rdata;
    assign srv_valid = (state_reg == S_CB) ? vld_fwd_reg[b_idx] : vld_rev_reg[a_reg];

    kpm_survive u_survive (
        .entry       (srv_entry),
        .entry_valid (srv_valid),
        .ratio_limit (ratio_limit_reg),
        .survives    (srv_ok)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        src_next       = src_reg;
        tgt_next       = tgt_reg;
        dist_next      = dist_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        vld_fwd_next   = vld_fwd_reg;
        vld_rev_next   = vld_rev_reg;
        pend_vld_next  = pend_vld_reg;
        pend_a_next    = pend_a_reg;
        pend_b_next    = pend_b_reg;
        pend_d_next    = pend_d_reg;
        out_vld_next   = 1'b0;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;
        out_d_next     = out_d_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op;
                    src_next  = source_point;
                    tgt_next  = target_point;
                    dist_next = distance;
                    a_next    = '0;
                    case (op)
                        OP_FWD:  state_next = S_UPD;
                        OP_REV:  state_next = S_UPD;
                        OP_FIN:  state_next = (na == '0) ? S_END : S_RA;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD:
            begin
                if (fwd_we)
                begin
                    vld_fwd_next[wr_addr] = 1'b1;
                end
                if (rev_we)
                begin
                    vld_rev_next[wr_addr] = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_RA:
            begin
                state_next = S_CA;
            end
            S_CA:
            begin
                b_next = rev_rdata.src;
                if (srv_ok && (USED_W'(rev_rdata.src) < nb))
                begin
                    state_next = S_CB;
                end
                else if (a_done)
                begin
                    state_next = S_END;
                end
                else
                begin
                    a_next     = a_inc[PT_W-1:0];
                    state_next = S_RA;
                end
            end
            S_CB:
            begin
                if (srv_ok && (fwd_rdata.src == IDX_W'(a_reg)))
                begin
                    // release the held survivor now that another follows
                    if (pend_vld_reg)
                    begin
                        out_vld_next   = 1'b1;
                        out_a_next     = pend_a_reg;
                        out_b_next     = pend_b_reg;
                        out_d_next     = pend_d_reg;
                        out_found_next = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    pend_vld_next = 1'b1;
                    pend_a_next   = IDX_W'(a_reg);
                    pend_b_next   = b_reg;
                    pend_d_next   = fwd_rdata.best;
                end
                if (a_done)
                begin
                    state_next = S_END;
                end
                else
                begin
                    a_next     = a_inc[PT_W-1:0];
                    state_next = S_RA;
                end
            end
            S_END:
            begin
                out_vld_next   = 1'b1;
                out_last_next  = 1'b1;
                out_found_next = pend_vld_reg;
                out_a_next     = pend_vld_reg ? pend_a_reg : '0;
                out_b_next     = pend_vld_reg ? pend_b_reg : '0;
                out_d_next     = pend_vld_reg ? pend_d_reg : '0;
                pend_vld_next  = 1'b0;
                vld_fwd_next   = '0;
                vld_rev_next   = '0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_FWD;
            src_reg       <= '0;
            tgt_reg       <= '0;
            dist_reg      <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            vld_fwd_reg   <= '0;
            vld_rev_reg   <= '0;
            pend_vld_reg  <= 1'b0;
            pend_a_reg    <= '0;
            pend_b_reg    <= '0;
            pend_d_reg    <= '0;
            out_vld_reg   <= 1'b0;
            out_a_reg     <= '0;
            out_b_reg     <= '0;
            out_d_reg     <= '0;
            out_found_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            src_reg       <= src_next;
            tgt_reg       <= tgt_next;
            dist_reg      <= dist_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            vld_fwd_reg   <= vld_fwd_next;
            vld_rev_reg   <= vld_rev_next;
            pend_vld_reg  <= pend_vld_next;
            pend_a_reg    <= pend_a_next;
            pend_b_reg    <= pend_b_next;
            pend_d_reg    <= pend_d_next;
            out_vld_reg   <= out_vld_next;
            out_a_reg     <= out_a_next;
            out_b_reg     <= out_b_next;
            out_d_reg     <= out_d_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign result_valid   = out_vld_reg;
    assign point_a        = out_a_reg;
    assign point_b        = out_b_reg;
    assign match_distance = out_d_reg;
    assign found          = out_found_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/kpm_checker.sv =====
// Port-level checker for the keypoint match filter, bound to the top level.
// Depends on kpm_pkg and keypoint_match_ratio_cross_check_unit.
`default_nettype none

module kpm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [kpm_pkg::OP_W-1:0]      op,
    input wire logic                          result_valid,
    input wire logic [kpm_pkg::IDX_W-1:0]     point_a,
    input wire logic [kpm_pkg::IDX_W-1:0]     point_b,
    input wire logic [kpm_pkg::DIST_W-1:0]    match_distance,
    input wire logic                          found,
    input wire logic                          last
);
    import kpm_pkg::*;

    // a known op started while idle always makes the block busy in the cycle after
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((op == OP_FWD) || (op == OP_REV) || (op == OP_FIN))) |=> busy)
        else $error("known op accepted without going busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("final result while still busy");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final result with the walk already over");

    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (last && (point_a == '0) && (point_b == '0)
                                      && (match_distance == '0)))
        else $error("not-found result malformed");

endmodule

bind keypoint_match_ratio_cross_check_unit kpm_checker u_kpm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .result_valid   (result_valid),
    .point_a        (point_a),
    .point_b        (point_b),
    .match_distance (match_distance),
    .found          (found),
    .last           (last)
);

`default_nettype wire

// ===== bench/keypoint_match_ratio_cross_check_unit_tb.sv =====
// Self-checking bench for the keypoint match filter: directed table, then random match rounds.
// Holds its own model of the match tables and the survival rule.
// Depends on kpm_pkg and keypoint_match_ratio_cross_check_unit.
`default_nettype none

module keypoint_match_ratio_cross_check_unit_tb;

    import kpm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DIRECTED_COUNT = 27;

    typedef struct packed {
        logic [IDX_W-1:0]  point_a;
        logic [IDX_W-1:0]  point_b;
        logic [DIST_W-1:0] dist_val;
        logic              found;
        logic              last;
    } match_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  tgt;
        logic [DIST_W-1:0] dist_val;
        logic              typed;
        match_result_t     exp;
    } directed_row_t;

    typedef struct packed {
        logic [DIST_W-1:0]  dist_limit;
        logic [RATIO_W-1:0] ratio_limit;
        logic [USED_W-1:0]  used_a;
        logic [USED_W-1:0]  used_b;
        int                 idle_pct;
        int                 items;
    } phase_t;

    localparam match_result_t NO_MATCH = '{6'd0, 6'd0, 10'd0, 1'b0, 1'b1};

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{OP_FIN,    6'd0,  6'd0,  10'd0,    1'b1, NO_MATCH},
        '{OP_FWD,    6'd5,  6'd9,  10'd100,  1'b0, '0},
        '{OP_REV,    6'd9,  6'd5,  10'd120,  1'b0, '0},
        '{OP_FIN,    6'd0,  6'd0,  10'd0,    1'b1, '{6'd5, 6'd9, 10'd100, 1'b1, 1'b1}},
        '{OP_FWD,    6'd63, 6'd63, 10'd512,  1'b0, '0},
        '{OP_REV,    6'd63, 6'd63, 10'd0,    1'b0, '0},
        '{OP_FIN,    6'd63, 6'd63, 10'd1023, 1'b1, '{6'd63, 6'd63, 10'd512, 1'b1, 1'b1}},
        '{OP_FWD,    6'd1,  6'd2,  10'd513,  1'b0, '0},
        '{OP_REV,    6'd2,  6'd1,  10'd10,   1'b0, '0},
        '{OP_FIN,    6'd0,  6'd0,  10'd0,    1'b1, NO_MATCH},
        '{OP_FWD,    6'd7,  6'd4,  10'd200,  1'b0, '0},
        '{OP_FWD,    6'd3,  6'd4,  10'd100,  1'b0, '0},
        '{OP_REV,    6'd4,  6'd3,  10'd50,   1'b0, '0},
        '{OP_FIN,    6'd0,  6'd0,  10'd0,    1'b1, '{6'd3, 6'd4, 10'd100, 1'b1, 1'b1}},
        '{OP_FWD,    6'd10, 6'd20, 10'd30,   1'b0, '0},
        '{OP_FWD,    6'd11, 6'd20, 10'd30,   1'b0, '0},
        '{OP_FWD,    6'd12, 6'd13, 10'd0,    1'b0, '0},
        '{OP_FWD,    6'd14, 6'd13, 10'd0,    1'b0, '0},
        '{OP_REV,    6'd20, 6'd10, 10'd1,    1'b0, '0},
        '{OP_REV,    6'd13, 6'd12, 10'd1,    1'b0, '0},
        '{OP_FIN,    6'd0,  6'd0,  10'd0,    1'b1, NO_MATCH},
        '{OP_FWD,    6'd0,  6'd1,  10'd5,    1'b0, '0},
        '{OP_REV,    6'd1,  6'd0,  10'd6,    1'b0, '0},
        '{OP_FWD,    6'd2,  6'd3,  10'd7,    1'b0, '0},
        '{OP_UNUSED, 6'd33, 6'd44, 10'd1023, 1'b0, '0},
        '{OP_REV,    6'd3,  6'd2,  10'd8,    1'b0, '0},
        '{OP_FIN,    6'd0,  6'd0,  10'd0,    1'b0, '0}
    };

    localparam phase_t PHASES [4] = '{
        '{10'd300,  9'd230, 7'd64, 7'd64,  17, 70},
        '{10'd1023, 9'd511, 7'd40, 7'd127, 73, 70},
        '{10'd0,    9'd0,   7'd0,  7'd1,   73, 25},
        '{10'd512,  9'd256, 7'd64, 7'd64,  0,  70}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    source_point;
    logic [IDX_W-1:0]    target_point;
    logic [DIST_W-1:0]   distance;
    logic                result_valid;
    logic [IDX_W-1:0]    point_a;
    logic [IDX_W-1:0]    point_b;
    logic [DIST_W-1:0]   match_distance;
    logic                found;
    logic                last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    keypoint_match_ratio_cross_check_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .source_point   (source_point),
        .target_point   (target_point),
        .distance       (distance),
        .result_valid   (result_valid),
        .point_a        (point_a),
        .point_b        (point_b),
        .match_distance (match_distance),
        .found          (found),
        .last           (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Model state: per-target tables and register shadows
    kpm_entry_t          fwd_table [POINTS];
    kpm_entry_t          rev_table [POINTS];
    logic [DIST_W-1:0]   cfg_dist_limit;
    logic [RATIO_W-1:0]  cfg_ratio_limit;
    logic [USED_W-1:0]   cfg_used_a;
    logic [USED_W-1:0]   cfg_used_b;

    match_result_t       pending_matches [$];
    match_result_t       walk_matches [$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  idle_pct = 17;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("keypoint_match_ratio_cross_check_unit_tb failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic kpm_entry_t fold_match(input kpm_entry_t e, input logic [IDX_W-1:0] src,
                                              input logic [DIST_W-1:0] dist_val);
        kpm_entry_t r;
        r = e;
        if (e.cnt == CNT_NONE)
        begin
            r.best = dist_val;
            r.src  = src;
            r.cnt  = CNT_ONE;
        end
        else
        begin
            if (dist_val < e.best)
            begin
                r.second = e.best;
                r.best   = dist_val;
                r.src    = src;
            end
            else if (e.cnt == CNT_ONE || dist_val < e.second)
            begin
                r.second = dist_val;
            end
            r.cnt = CNT_TWO;
        end
        return r;
    endfunction

    function automatic bit ratio_ok(input kpm_entry_t e);
        int unsigned lhs;
        int unsigned rhs;
        lhs = 32'(e.best) * 256;
        rhs = 32'(cfg_ratio_limit) * 32'(e.second);
        if (e.cnt == CNT_ONE)
            return 1'b1;
        if (e.cnt == CNT_NONE)
            return 1'b0;
        return lhs < rhs;
    endfunction

    task automatic clear_tables();
        for (int i = 0; i < POINTS; i++)
        begin
            fwd_table[i] = '0;
            rev_table[i] = '0;
        end
    endtask

    // Update the tables for one accepted item; on finish, queue the mutual survivors (if asked) and clear the tables
    task automatic predict_matches(input logic [OP_W-1:0] item_op, input logic [IDX_W-1:0] src,
                                   input logic [IDX_W-1:0] tgt, input logic [DIST_W-1:0] dist_val,
                                   input bit queue_them);
        int na;
        int nb;
        int b;
        match_result_t m;
        na = (cfg_used_a > USED_MAX) ? POINTS : int'(cfg_used_a);
        nb = (cfg_used_b > USED_MAX) ? POINTS : int'(cfg_used_b);
        case (item_op)
            OP_FWD:
                if (dist_val <= cfg_dist_limit)
                    fwd_table[tgt] = fold_match(fwd_table[tgt], src, dist_val);
            OP_REV:
                if (dist_val <= cfg_dist_limit)
                    rev_table[tgt] = fold_match(rev_table[tgt], src, dist_val);
            OP_FIN:
            begin
                walk_matches.delete();
                for (int a = 0; a < na; a++)
                begin
                    if (ratio_ok(rev_table[a]))
                    begin
                        b = int'(rev_table[a].src);
                        if (b < nb && ratio_ok(fwd_table[b]) && int'(fwd_table[b].src) == a)
                        begin
                            m = '{IDX_W'(a), IDX_W'(b), fwd_table[b].best, 1'b1, 1'b0};
                            walk_matches = {walk_matches, m};
                        end
                    end
                end
                if (walk_matches.size() == 0)
                    walk_matches = {walk_matches, NO_MATCH};
                else
                    walk_matches[walk_matches.size() - 1].last = 1'b1;
                if (queue_them)
                    foreach (walk_matches[i])
                        pending_matches = {pending_matches, walk_matches[i]};
                clear_tables();
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [OP_W-1:0] item_op, input logic [IDX_W-1:0] src,
                             input logic [IDX_W-1:0] tgt, input logic [DIST_W-1:0] dist_val,
                             input bit typed, input match_result_t typed_exp);
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start        <= 1'b1;
        op           <= item_op;
        source_point <= src;
        target_point <= tgt;
        distance     <= dist_val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_matches(item_op, src, tgt, dist_val, !typed);
        if (typed)
            pending_matches = {pending_matches, typed_exp};
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        // loads give no result, so let a trailing one finish
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        if (got !== want)
            report_error($sformatf("register %0d reads %0h, want %0h", idx, got, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] kept;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DIST_LIMIT:  cfg_dist_limit  = value[DIST_W-1:0];
            REG_RATIO_LIMIT: cfg_ratio_limit = value[RATIO_W-1:0];
            REG_POINTS_A:    cfg_used_a      = value[USED_W-1:0];
            REG_POINTS_B:    cfg_used_b      = value[USED_W-1:0];
            default: ;
        endcase
        case (idx)
            REG_DIST_LIMIT:  kept = PDATA_W'(cfg_dist_limit);
            REG_RATIO_LIMIT: kept = PDATA_W'(cfg_ratio_limit);
            REG_POINTS_A:    kept = PDATA_W'(cfg_used_a);
            default:         kept = PDATA_W'(cfg_used_b);
        endcase
        apb_read_check(idx, kept);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return DIST_W'($urandom_range(0, 300));
        if (r < 93)
            return DIST_W'($urandom_range(0, 512));
        return DIST_W'($urandom_range(513, 1023));
    endfunction

    // One round: loads around a small window of points or all of them, half the steps mutual pairs, then finish
    task automatic run_round(inout int counted);
        int span;
        int base;
        int steps;
        int kind;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        span  = ($urandom_range(0, 3) == 0) ? 63 : 7;
        base  = (span == 63) ? 0 : $urandom_range(0, 56);
        steps = $urandom_range(1, 12);
        for (int s = 0; s < steps; s++)
        begin
            a    = IDX_W'(base + $urandom_range(0, span));
            b    = IDX_W'(base + $urandom_range(0, span));
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                send_item(OP_FWD, a, b, pick_distance(), 1'b0, '0);
                send_item(OP_REV, b, a, pick_distance(), 1'b0, '0);
                counted += 2;
            end
            else if (kind < 93)
            begin
                send_item($urandom_range(0, 1) ? OP_REV : OP_FWD, a, b, pick_distance(),
                          1'b0, '0);
                counted++;
            end
            else
            begin
                send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), DIST_W'($urandom),
                          1'b0, '0);
            end
        end
        send_item(OP_FIN, IDX_W'($urandom), IDX_W'($urandom), DIST_W'($urandom), 1'b0, '0);
        counted++;
    endtask

    always @(posedge clk)
    begin
        match_result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (pending_matches.size() == 0)
            begin
                report_error($sformatf("result with none pending: a=%0d b=%0d d=%0d f=%0b l=%0b",
                                       point_a, point_b, match_distance, found, last));
            end
            else
            begin
                want = pending_matches.pop_front();
                if (point_a !== want.point_a)
                    report_error($sformatf("point_a %0d, want %0d", point_a, want.point_a));
                if (point_b !== want.point_b)
                    report_error($sformatf("point_b %0d, want %0d", point_b, want.point_b));
                if (match_distance !== want.dist_val)
                    report_error($sformatf("match_distance %0d, want %0d",
                                           match_distance, want.dist_val));
                if (found !== want.found)
                    report_error($sformatf("found %0b, want %0b", found, want.found));
                if (last !== want.last)
                    report_error($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    initial
    begin
        int counted;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_FWD;
        source_point = '0;
        target_point = '0;
        distance     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cfg_dist_limit  = DIST_LIMIT_RST;
        cfg_ratio_limit = RATIO_LIMIT_RST;
        cfg_used_a      = USED_MAX;
        cfg_used_b      = USED_MAX;
        clear_tables();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        apb_read_check(REG_DIST_LIMIT,  PDATA_W'(DIST_LIMIT_RST));
        apb_read_check(REG_RATIO_LIMIT, PDATA_W'(RATIO_LIMIT_RST));
        apb_read_check(REG_POINTS_A,    PDATA_W'(USED_MAX));
        apb_read_check(REG_POINTS_B,    PDATA_W'(USED_MAX));

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].src, DIRECTED_ROWS[i].tgt,
                      DIRECTED_ROWS[i].dist_val, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);

        foreach (PHASES[p])
        begin
            drain_and_settle();
            write_register(REG_DIST_LIMIT,  PDATA_W'(PHASES[p].dist_limit));
            write_register(REG_RATIO_LIMIT, PDATA_W'(PHASES[p].ratio_limit));
            write_register(REG_POINTS_A,    PDATA_W'(PHASES[p].used_a));
            write_register(REG_POINTS_B,    PDATA_W'(PHASES[p].used_b));
            idle_pct = PHASES[p].idle_pct;
            counted = 0;
            while (counted < PHASES[p].items)
                run_round(counted);
        end

        drain_and_settle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("keypoint_match_ratio_cross_check_unit_tb passed");
        else
            $display("keypoint_match_ratio_cross_check_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/kpm_pkg.sv
rtl/kpm_ram.sv
rtl/kpm_update.sv
rtl/kpm_survive.sv
rtl/keypoint_match_ratio_cross_check_unit.sv
rtl/kpm_checker.sv
bench/keypoint_match_ratio_cross_check_unit_tb.sv
